>>> sv/s2l_pkg.sv
package s2l_pkg;

	localparam int TABLE_YEARS = 201;
	localparam int IDX_W       = 8;
	localparam int DAYS_W      = 17;
	localparam int WORD_W      = 17;
	localparam int YLEN_W      = 9;

	localparam logic [11:0] BASE_YEAR  = 12'd1900;
	localparam logic [11:0] LAST_YEAR  = 12'd2100;
	localparam logic [3:0]  LAST_MONTH = 4'd12;
	localparam logic [4:0]  BASE_DAY   = 5'd31;
	localparam logic [8:0]  YEAR_BASE_LEN = 9'd348;

	// one word per lunar year: bits 15..4 months 1..12 long, 3..0 leap month, 16 leap long
	localparam logic [WORD_W-1:0] LUNAR_ROM [0:TABLE_YEARS-1] = '{
		17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554,
		17'h056a0, 17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250,
		17'h1d255, 17'h0b540, 17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970,
		17'h0a4b0, 17'h0b4b5, 17'h06a50, 17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570,
		17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0, 17'h0ea50, 17'h06e95, 17'h05ad0,
		17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950, 17'h0d4a0, 17'h1d8a6,
		17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2, 17'h0a950,
		17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5d0, 17'h14573,
		17'h052d0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60,
		17'h0aae4, 17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0,
		17'h096d0, 17'h04dd5, 17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558,
		17'h0b540, 17'h0b5a0, 17'h195a6, 17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0,
		17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46, 17'h0ab60, 17'h09570, 17'h04af5,
		17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58, 17'h055c0, 17'h0ab60,
		17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50, 17'h07552,
		17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
		17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0,
		17'h0a930, 17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6,
		17'h0a4e0, 17'h0d260, 17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0,
		17'h04bd7, 17'h04ad0, 17'h0a4d0, 17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45,
		17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0, 17'h0a577, 17'h0a4b0, 17'h0aa50,
		17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63, 17'h09370, 17'h049f8, 17'h04970,
		17'h064b0, 17'h168a6, 17'h0ea50, 17'h06aa0, 17'h1a6c4, 17'h0aae0, 17'h092e0,
		17'h0d2e3, 17'h0c960, 17'h0d557, 17'h0d4a0, 17'h0da50, 17'h05d55, 17'h056a0,
		17'h0a6d0, 17'h055d4, 17'h052d0, 17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6,
		17'h0ad50, 17'h055a0, 17'h0aba4, 17'h0a5b0, 17'h052b0, 17'h0b273, 17'h06930,
		17'h07337, 17'h06aa0, 17'h0ad50, 17'h14b55, 17'h04b60, 17'h0a570, 17'h054e4,
		17'h0d260, 17'h0e968, 17'h0d520, 17'h0daa0, 17'h16aa6, 17'h056d0, 17'h04ae0,
		17'h0a9d4, 17'h0a4d0, 17'h0d150, 17'h0f252, 17'h0d520
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GYEAR,
		ST_GMON,
		ST_GDAY,
		ST_ADJ,
		ST_LYW1,
		ST_LYW2,
		ST_LYSTEP,
		ST_LMON,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ALU_HOLD,
		ALU_CLR,
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t           op;
		logic [DAYS_W-1:0] operand;
	} alu_ctrl_t;

	function automatic logic [4:0] greg_mlen(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd2:                        len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
			default:                     len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [4:0] lunar_mlen(input logic [WORD_W-1:0] w, input logic [3:0] m);
		logic [4:0] bit_idx;
		bit_idx = 5'd16 - {1'b0, m};
		return w[bit_idx] ? 5'd30 : 5'd29;
	endfunction

	function automatic logic [4:0] leap_mlen(input logic [WORD_W-1:0] w);
		logic [4:0] len;
		if (w[3:0] == 4'd0) len = 5'd0;
		else len = w[16] ? 5'd30 : 5'd29;
		return len;
	endfunction

endpackage

>>> sv/s2l_rom.sv
module s2l_rom (
	input  logic                           clk,
	input  logic [s2l_pkg::IDX_W-1:0]      idx,
	output logic [s2l_pkg::WORD_W-1:0]     word_q,
	output logic [s2l_pkg::YLEN_W-1:0]     ylen_q
);

	logic [s2l_pkg::YLEN_W-1:0] ylen;

	// total days of the lunar year held in word_q
	always_comb begin
		ylen = s2l_pkg::YEAR_BASE_LEN
			+ s2l_pkg::YLEN_W'($countones(word_q[15:4]))
			+ {4'd0, s2l_pkg::leap_mlen(word_q)};
	end

	always_ff @(posedge clk) begin
		if (32'(idx) < s2l_pkg::TABLE_YEARS) word_q <= s2l_pkg::LUNAR_ROM[idx];
		else word_q <= '0;
		ylen_q <= ylen;
	end

endmodule

>>> sv/s2l_alu.sv
module s2l_alu (
	input  logic                           clk,
	input  s2l_pkg::alu_ctrl_t             ctrl,
	output logic [s2l_pkg::DAYS_W-1:0]     days_q,
	output logic                           lt
);

	assign lt = days_q < ctrl.operand;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			s2l_pkg::ALU_HOLD: days_q <= days_q;
			s2l_pkg::ALU_CLR:  days_q <= '0;
			s2l_pkg::ALU_ADD:  days_q <= days_q + ctrl.operand;
			s2l_pkg::ALU_SUB:  days_q <= days_q - ctrl.operand;
		endcase
	end

endmodule

>>> sv/solar_to_lunar_date.sv
// Gregorian to Chinese lunar date converter for years 1900 to 2100. One date is taken
// at a time and s_tready stays low until its result has moved to the output register;
// the next date may be taken while that result still waits on the master side. A
// single add/subtract-and-compare unit on the day count does all the work: it takes
// the date, adds one year length per Gregorian year from 1900 and one month length per
// month of the input year before it, adds the day and takes off the 1900-01-31 offset,
// then per lunar year looked at reads the table, forms the year length and steps, and
// walks the lunar months including a leap month before it hands over the result.
// Out-of-range years or months and dates before 1900-01-31 are echoed with converted
// low.
module solar_to_lunar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // year[11:0], month[15:12], day[20:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // year[11:0], month[15:12], day[20:16],
	                               // is_leap_month[21]
	output logic        m_tuser    // converted
);

	s2l_pkg::state_t   state_q, state_d;
	s2l_pkg::alu_ctrl_t alu_ctrl;

	logic [s2l_pkg::DAYS_W-1:0] days_q;
	logic                       lt;
	logic [s2l_pkg::WORD_W-1:0] word_q;
	logic [s2l_pkg::YLEN_W-1:0] ylen_q;

	logic [11:0] year_q;
	logic [3:0]  mon_q;
	logic [4:0]  day_q;
	logic        conv_q;
	logic [7:0]  yrem_q;
	logic [1:0]  c4_q;
	logic [6:0]  c100_q;
	logic [8:0]  c400_q;
	logic [3:0]  mi_q;
	logic [s2l_pkg::IDX_W-1:0] idx_q;
	logic        phase_q;
	logic [3:0]  lmon_q;
	logic        leap_q;

	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;
	logic        m_tuser_q;

	logic        accept;
	logic        bad_in;
	logic        gleap;
	logic        more_years;
	logic        out_free;
	logic [4:0]  lday;
	logic [11:0] lyear;

	s2l_alu u_alu (
		.clk    (clk),
		.ctrl   (alu_ctrl),
		.days_q (days_q),
		.lt     (lt)
	);

	s2l_rom u_rom (
		.clk    (clk),
		.idx    (idx_q),
		.word_q (word_q),
		.ylen_q (ylen_q)
	);

	assign s_tready = (state_q == s2l_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign bad_in   = (s_tdata[11:0] < s2l_pkg::BASE_YEAR) || (s_tdata[11:0] > s2l_pkg::LAST_YEAR)
		|| (s_tdata[15:12] == 4'd0) || (s_tdata[15:12] > s2l_pkg::LAST_MONTH);
	// gregorian leap test from running residues of the year being walked
	assign gleap      = ((c4_q == 2'd0) && (c100_q != 7'd0)) || (c400_q == 9'd0);
	assign more_years = (32'(idx_q) + 1) < s2l_pkg::TABLE_YEARS;
	assign out_free   = !m_tvalid_q || m_tready;
	assign lday       = (days_q >= s2l_pkg::DAYS_W'(s2l_pkg::BASE_DAY)) ? s2l_pkg::BASE_DAY
		: days_q[4:0] + 5'd1;
	assign lyear      = s2l_pkg::BASE_YEAR + {4'd0, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= s2l_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d          = state_q;
		alu_ctrl.op      = s2l_pkg::ALU_HOLD;
		alu_ctrl.operand = '0;
		unique case (state_q)
			s2l_pkg::ST_IDLE: begin
				if (accept) begin
					alu_ctrl.op = s2l_pkg::ALU_CLR;
					state_d = bad_in ? s2l_pkg::ST_DONE : s2l_pkg::ST_GYEAR;
				end
			end
			s2l_pkg::ST_GYEAR: begin
				alu_ctrl.operand = gleap ? s2l_pkg::DAYS_W'(366) : s2l_pkg::DAYS_W'(365);
				if (yrem_q == 8'd0) state_d = s2l_pkg::ST_GMON;
				else alu_ctrl.op = s2l_pkg::ALU_ADD;
			end
			s2l_pkg::ST_GMON: begin
				alu_ctrl.operand = {12'd0, s2l_pkg::greg_mlen(mi_q, gleap)};
				if (mi_q == mon_q) state_d = s2l_pkg::ST_GDAY;
				else alu_ctrl.op = s2l_pkg::ALU_ADD;
			end
			s2l_pkg::ST_GDAY: begin
				alu_ctrl.operand = {12'd0, day_q};
				alu_ctrl.op = s2l_pkg::ALU_ADD;
				state_d = s2l_pkg::ST_ADJ;
			end
			s2l_pkg::ST_ADJ: begin
				alu_ctrl.operand = {12'd0, s2l_pkg::BASE_DAY};
				if (lt) state_d = s2l_pkg::ST_DONE;
				else begin
					alu_ctrl.op = s2l_pkg::ALU_SUB;
					state_d = s2l_pkg::ST_LYW1;
				end
			end
			s2l_pkg::ST_LYW1: state_d = s2l_pkg::ST_LYW2;
			s2l_pkg::ST_LYW2: state_d = s2l_pkg::ST_LYSTEP;
			s2l_pkg::ST_LYSTEP: begin
				alu_ctrl.operand = {8'd0, ylen_q};
				if (more_years && !lt) begin
					alu_ctrl.op = s2l_pkg::ALU_SUB;
					state_d = s2l_pkg::ST_LYW1;
				end else state_d = s2l_pkg::ST_LMON;
			end
			s2l_pkg::ST_LMON: begin
				alu_ctrl.operand = phase_q ? {12'd0, s2l_pkg::leap_mlen(word_q)}
					: {12'd0, s2l_pkg::lunar_mlen(word_q, mi_q)};
				if (lt) state_d = s2l_pkg::ST_DONE;
				else begin
					alu_ctrl.op = s2l_pkg::ALU_SUB;
					if (!(!phase_q && word_q[3:0] == mi_q) && mi_q == s2l_pkg::LAST_MONTH)
						state_d = s2l_pkg::ST_DONE;
				end
			end
			s2l_pkg::ST_DONE: begin
				if (out_free) state_d = s2l_pkg::ST_IDLE;
			end
			default: state_d = s2l_pkg::ST_IDLE;
		endcase
	end

	// walk counters and item registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			s2l_pkg::ST_IDLE: begin
				if (accept) begin
					year_q  <= s_tdata[11:0];
					mon_q   <= s_tdata[15:12];
					day_q   <= s_tdata[20:16];
					conv_q  <= !bad_in;
					yrem_q  <= 8'(s_tdata[11:0] - s2l_pkg::BASE_YEAR);
					c4_q    <= 2'd0;
					c100_q  <= 7'd0;
					c400_q  <= 9'd300;
					mi_q    <= 4'd1;
					idx_q   <= '0;
					phase_q <= 1'b0;
					lmon_q  <= s2l_pkg::LAST_MONTH;
					leap_q  <= 1'b0;
				end
			end
			s2l_pkg::ST_GYEAR: begin
				if (yrem_q != 8'd0) begin
					yrem_q <= yrem_q - 8'd1;
					c4_q   <= c4_q + 2'd1;
					c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
					c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
				end
			end
			s2l_pkg::ST_GMON: begin
				if (mi_q != mon_q) mi_q <= mi_q + 4'd1;
			end
			s2l_pkg::ST_ADJ: begin
				if (lt) conv_q <= 1'b0;
			end
			s2l_pkg::ST_LYSTEP: begin
				if (more_years && !lt) idx_q <= idx_q + 1'b1;
				else begin
					mi_q    <= 4'd1;
					phase_q <= 1'b0;
				end
			end
			s2l_pkg::ST_LMON: begin
				if (lt) begin
					lmon_q <= mi_q;
					leap_q <= phase_q;
				end else if (!phase_q && word_q[3:0] == mi_q) phase_q <= 1'b1;
				else if (mi_q == s2l_pkg::LAST_MONTH) begin
					lmon_q <= s2l_pkg::LAST_MONTH;
					leap_q <= 1'b0;
				end else begin
					mi_q    <= mi_q + 4'd1;
					phase_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid_q <= 1'b0;
		else if (state_q == s2l_pkg::ST_DONE && out_free) m_tvalid_q <= 1'b1;
		else if (m_tready) m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == s2l_pkg::ST_DONE && out_free) begin
			m_tuser_q <= conv_q;
			if (conv_q) m_tdata_q <= {2'b00, leap_q, lday, lmon_q, lyear};
			else m_tdata_q <= {3'b000, day_q, mon_q, year_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != s2l_pkg::ST_IDLE)
		else $error("accepted beat did not start a conversion");

	a_idx_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == s2l_pkg::ST_LYSTEP |-> 32'(idx_q) < s2l_pkg::TABLE_YEARS)
		else $error("lunar year index beyond table");

	a_echo_no_leap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tdata[21])
		else $error("leap flag set on echoed date");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[15:12] != 4'd0 && m_tdata[15:12] <= s2l_pkg::LAST_MONTH
			&& m_tdata[20:16] != 5'd0)
		else $error("converted lunar month or day out of range");

endmodule

>>> tb/sv/testbench.sv
module testbench;

	localparam int FIRST_YEAR  = 1900;
	localparam int FINAL_YEAR  = 2100;
	localparam int RANDOM_DATES = 450;
	localparam int CALM_TAIL   = 40;
	localparam int DRAIN_WAIT  = 850;
	localparam int STALL_LIMIT = 20000;

	// one word per lunar year from 1900: bits 15..4 month 1..12 long, 3..0 leap month,
	// bit 16 leap month long
	localparam logic [16:0] MOON_TABLE [0:200] = '{
		17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554, 17'h056a0,
		17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250, 17'h1d255, 17'h0b540,
		17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970, 17'h0a4b0, 17'h0b4b5, 17'h06a50,
		17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570, 17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0,
		17'h0ea50, 17'h06e95, 17'h05ad0, 17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950,
		17'h0d4a0, 17'h1d8a6, 17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2,
		17'h0a950, 17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5d0, 17'h14573,
		17'h052d0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60, 17'h0aae4,
		17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0, 17'h096d0, 17'h04dd5,
		17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558, 17'h0b540, 17'h0b5a0, 17'h195a6,
		17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0, 17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46,
		17'h0ab60, 17'h09570, 17'h04af5, 17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58,
		17'h055c0, 17'h0ab60, 17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50,
		17'h07552, 17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
		17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0, 17'h0a930,
		17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6, 17'h0a4e0, 17'h0d260,
		17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0, 17'h04bd7, 17'h04ad0, 17'h0a4d0,
		17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45, 17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0,
		17'h0a577, 17'h0a4b0, 17'h0aa50, 17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63, 17'h09370,
		17'h049f8, 17'h04970, 17'h064b0, 17'h168a6, 17'h0ea50, 17'h06aa0, 17'h1a6c4, 17'h0aae0,
		17'h092e0, 17'h0d2e3, 17'h0c960, 17'h0d557, 17'h0d4a0, 17'h0da50, 17'h05d55, 17'h056a0,
		17'h0a6d0, 17'h055d4, 17'h052d0, 17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6, 17'h0ad50,
		17'h055a0, 17'h0aba4, 17'h0a5b0, 17'h052b0, 17'h0b273, 17'h06930, 17'h07337, 17'h06aa0,
		17'h0ad50, 17'h14b55, 17'h04b60, 17'h0a570, 17'h054e4, 17'h0d260, 17'h0e968, 17'h0d520,
		17'h0daa0, 17'h16aa6, 17'h056d0, 17'h04ae0, 17'h0a9d4, 17'h0a4d0, 17'h0d150, 17'h0f252,
		17'h0d520
	};

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} solar_date_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        leap;
		logic        conv;
	} lunar_date_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // year[11:0], month[15:12], day[20:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // year[11:0], month[15:12], day[20:16],
	                             // is_leap_month[21]
	logic        m_tuser;        // converted

	solar_date_t dates_pending[$];
	lunar_date_t lunar_due[$];
	int dates_total = 0;
	int dates_taken = 0;
	int errors = 0;
	int n_conv = 0;
	int n_leap = 0;
	int n_echo = 0;
	int idle_cycles = 0;
	int send_gap = 0;
	int take_stall = 0;
	bit in_beat = 1'b0;

	solar_to_lunar_date i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit greg_leap_year(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic lunar_date_t lunar_of_date(input solar_date_t sd);
		lunar_date_t r;
		int days;
		int len;
		int y;
		int m;
		int idx;
		int leap_mon;
		logic [16:0] word;
		bit hit;
		r.year  = sd.year;
		r.month = sd.month;
		r.day   = sd.day;
		r.leap  = 1'b0;
		r.conv  = 1'b0;
		if (sd.year < FIRST_YEAR || sd.year > FINAL_YEAR || sd.month < 1 || sd.month > 12)
			return r;
		days = 0;
		for (y = FIRST_YEAR; y < sd.year; y++)
			days += greg_leap_year(y) ? 366 : 365;
		for (m = 1; m < sd.month; m++) begin
			case (m)
				2:          days += greg_leap_year(int'(sd.year)) ? 29 : 28;
				4, 6, 9, 11: days += 30;
				default:    days += 31;
			endcase
		end
		days += int'(sd.day);
		// lunar 1900 month 1 day 1 falls on 1900-01-31
		if (days < 31)
			return r;
		days -= 31;
		idx = 0;
		while (idx < FINAL_YEAR - FIRST_YEAR) begin
			word = MOON_TABLE[idx];
			len = 348 + $countones(word[15:4]);
			if (word[3:0] != 0)
				len += word[16] ? 30 : 29;
			if (days < len)
				break;
			days -= len;
			idx++;
		end
		word = MOON_TABLE[idx];
		leap_mon = int'(word[3:0]);
		r.year = 12'(FIRST_YEAR + idx);
		r.month = 4'd12;
		hit = 1'b0;
		for (m = 1; m <= 12 && !hit; m++) begin
			len = word[16 - m] ? 30 : 29;
			if (days < len) begin
				r.month = 4'(m);
				hit = 1'b1;
			end else begin
				days -= len;
				// the leap month follows its normal month once
				if (leap_mon == m) begin
					len = word[16] ? 30 : 29;
					if (days < len) begin
						r.month = 4'(m);
						r.leap = 1'b1;
						hit = 1'b1;
					end else begin
						days -= len;
					end
				end
			end
		end
		r.day = (days + 1 > 31) ? 5'd31 : 5'(days + 1);
		r.conv = 1'b1;
		return r;
	endfunction

	task automatic queue_date(input int y, input int m, input int d);
		solar_date_t sd;
		sd.year  = 12'(y);
		sd.month = 4'(m);
		sd.day   = 5'(d);
		dates_pending.push_back(sd);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// beat bookkeeping, result checking and the stall watchdog
	always @(posedge clk) begin
		lunar_date_t want;
		solar_date_t seen;
		bit out_beat;
		out_beat = m_tvalid && m_tready;
		in_beat = s_tvalid && s_tready;
		if (out_beat) begin
			if (lunar_due.size() == 0) begin
				$error("result beat with no date outstanding: %h / %b", m_tdata, m_tuser);
				errors++;
			end else begin
				want = lunar_due.pop_front();
				check_field("year", int'(want.year), int'(m_tdata[11:0]));
				check_field("month", int'(want.month), int'(m_tdata[15:12]));
				check_field("day", int'(want.day), int'(m_tdata[20:16]));
				check_field("is_leap_month", int'(want.leap), int'(m_tdata[21]));
				check_field("converted", int'(want.conv), int'(m_tuser));
				if (want.conv) n_conv++;
				else n_echo++;
				if (want.leap) n_leap++;
			end
		end
		if (in_beat) begin
			seen.year  = s_tdata[11:0];
			seen.month = s_tdata[15:12];
			seen.day   = s_tdata[20:16];
			lunar_due.push_back(lunar_of_date(seen));
			dates_taken++;
		end
		if (arst_n) begin
			if (in_beat || out_beat) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	// date driver
	always @(negedge clk) begin
		solar_date_t sd;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_beat) begin
			s_tvalid <= 1'b1;
		end else if (send_gap > 0) begin
			send_gap--;
			s_tvalid <= 1'b0;
		end else if (dates_pending.size() == 0) begin
			s_tvalid <= 1'b0;
		end else if (dates_pending.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
			send_gap = $urandom_range(1, 14) - 1;
			s_tvalid <= 1'b0;
		end else begin
			sd = dates_pending.pop_front();
			s_tdata <= {3'b000, sd.day, sd.month, sd.year};
			s_tvalid <= 1'b1;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (take_stall > 0) begin
			take_stall--;
			m_tready <= 1'b0;
		end else if (dates_pending.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
			take_stall = $urandom_range(1, 14) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		int sel;
		int y;
		int m;
		int d;

		// first convertible day, its neighbours before it, then the year and month bounds
		queue_date(1900, 1, 31);
		queue_date(1900, 1, 30);
		queue_date(1900, 1, 0);
		queue_date(1899, 12, 31);
		queue_date(0, 0, 0);
		queue_date(4095, 15, 31);
		queue_date(2101, 1, 1);
		queue_date(2100, 12, 31);
		queue_date(2000, 0, 15);
		queue_date(2000, 13, 1);
		// leap month entry and exit
		queue_date(2020, 5, 23);
		queue_date(2020, 6, 20);
		queue_date(2020, 6, 21);
		queue_date(2023, 3, 22);
		queue_date(2033, 12, 22);
		queue_date(1900, 9, 24);
		// day zero and days past the month end roll over; then leap days and plain dates
		queue_date(2000, 3, 0);
		queue_date(2001, 2, 31);
		queue_date(2001, 4, 31);
		queue_date(2000, 2, 29);
		queue_date(1900, 2, 29);
		queue_date(2100, 2, 29);
		queue_date(2024, 2, 10);
		queue_date(1901, 1, 1);
		queue_date(2012, 12, 31);

		repeat (RANDOM_DATES) begin
			sel = $urandom_range(0, 99);
			if (sel < 8)
				y = $urandom_range(0, 4095);
			else
				y = $urandom_range(FIRST_YEAR, FINAL_YEAR);
			if ($urandom_range(0, 19) == 0)
				m = $urandom_range(0, 15);
			else
				m = $urandom_range(1, 12);
			if ($urandom_range(0, 19) == 0)
				d = $urandom_range(0, 31);
			else
				d = $urandom_range(1, 31);
			// straddle the start of the table now and then
			if (sel >= 8 && sel < 12) begin
				y = FIRST_YEAR;
				m = 1;
			end
			queue_date(y, m, d);
		end
		dates_total = dates_pending.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (dates_taken < dates_total || lunar_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d dates sent, %0d converted (%0d inside a leap month), %0d echoed",
			dates_total, n_conv, n_leap, n_echo);
		$display("inputs spanned the whole year and month fields, day zero and month overruns");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
sv/s2l_pkg.sv
sv/s2l_rom.sv
sv/s2l_alu.sv
sv/solar_to_lunar_date.sv
tb/sv/testbench.sv
